// ===== hdl/hnfp_pkg.sv =====
package hnfp_pkg;

  // Default width of the remaining-byte counter.
  localparam int LEN_BITS_DEF = 16;

  // Payload limit register: reset value and working range.
  localparam logic [11:0] MAX_PAYLOAD_RESET = 12'd1400;
  localparam logic [11:0] MAX_PAYLOAD_MIN   = 12'd2;
  localparam logic [11:0] MAX_PAYLOAD_MAX   = 12'd2048;

  // FU-A header construction.
  localparam logic [7:0] NRI_MASK      = 8'h60;
  localparam logic [7:0] FU_A_TYPE     = 8'd28;
  localparam logic [7:0] NAL_TYPE_MASK = 8'h1F;
  localparam logic [7:0] FU_START_BIT  = 8'h80;
  localparam logic [7:0] FU_END_BIT    = 8'h40;

  // Most results one input byte can cause.
  localparam int MAX_RESULTS = 3;

  // Input request.
  typedef struct packed {
    logic [7:0]  data_byte;
    logic        nal_start;
    logic [15:0] nal_length;
  } hnfp_in_t;

  // Result request.
  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        packet_first;
    logic        packet_last;
    logic [15:0] packet_seq;
    logic        run_end;
  } hnfp_out_t;

  // All results caused by one input byte, handed from the core to the emitter.
  typedef struct packed {
    logic [1:0]                    cnt;
    hnfp_out_t [MAX_RESULTS-1:0]   res;
  } hnfp_bundle_t;

endpackage

// ===== hdl/hnfp_core.sv =====
module hnfp_core import hnfp_pkg::*; #(
  parameter int LEN_BITS = LEN_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_stall,
  input  hnfp_in_t     in_data,
  input  logic         cfg_valid,
  input  logic [11:0]  cfg_data,
  input  logic         load_ok,
  output logic         bundle_load,
  output hnfp_bundle_t bundle
);

  // Width that holds both a saturated length and the payload limit.
  localparam int CW = (LEN_BITS > 16) ? LEN_BITS : 16;

  logic                item_valid_r;
  hnfp_in_t            item_r;
  logic [11:0]         max_payload_r;
  logic [15:0]         seq_r, seq_nxt;
  logic [7:0]          hdr_r, hdr_nxt;
  logic                frag_r, frag_nxt;
  logic [LEN_BITS-1:0] left_r, left_nxt;
  logic [10:0]         chunk_r, chunk_nxt;
  logic                ffrag_r, ffrag_nxt;

  logic                in_fire;
  logic                item_take;
  logic [11:0]         mp;
  logic [CW-1:0]       mp_ext;
  logic [15:0]         len16;
  logic [CW-1:0]       len_ext;
  logic [CW-1:0]       len_sat;
  logic [LEN_BITS-1:0] len;
  logic [15:0]         seq_use;
  logic                abandon;
  logic                last;
  logic [11:0]         chunk_inc;
  logic [7:0]          fu_hdr;
  hnfp_bundle_t        bnd;

  // Input register: holds one request until the core can hand its results on.
  assign in_stall  = item_valid_r & ~load_ok;
  assign in_fire   = in_valid & ~in_stall;
  assign item_take = item_valid_r & load_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else begin
      item_valid_r <= in_fire | (item_valid_r & ~item_take);
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r <= in_data;
    end
  end

  // Payload limit register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_payload_r <= MAX_PAYLOAD_RESET;
    end else if (cfg_valid) begin
      max_payload_r <= cfg_data;
    end
  end

  // Clamp the limit into its working range.
  always_comb begin
    if (max_payload_r < MAX_PAYLOAD_MIN) begin
      mp = MAX_PAYLOAD_MIN;
    end else if (max_payload_r > MAX_PAYLOAD_MAX) begin
      mp = MAX_PAYLOAD_MAX;
    end else begin
      mp = max_payload_r;
    end
  end
  assign mp_ext = CW'(mp);

  // Length of a new NAL: zero counts as one, then saturate to the counter width.
  assign len16   = (item_r.nal_length == 16'd0) ? 16'd1 : item_r.nal_length;
  assign len_ext = CW'(len16);
  assign len_sat = (len_ext > CW'({LEN_BITS{1'b1}})) ? CW'({LEN_BITS{1'b1}}) : len_ext;
  assign len     = len_sat[LEN_BITS-1:0];

  // An open packet of an abandoned NAL still uses up its sequence number.
  assign abandon   = (left_r != '0) & (~frag_r | (chunk_r != 11'd0));
  assign chunk_inc = {1'b0, chunk_r} + 12'd1;

  // FU header: NAL type with the start and end marks.
  always_comb begin
    fu_hdr = hdr_r & NAL_TYPE_MASK;
    if (ffrag_r) begin
      fu_hdr = fu_hdr | FU_START_BIT;
    end
    if (CW'(left_r) <= mp_ext) begin
      fu_hdr = fu_hdr | FU_END_BIT;
    end
  end

  // Step logic: next state and the results of the request in the input register.
  always_comb begin
    seq_use   = seq_r;
    seq_nxt   = seq_r;
    hdr_nxt   = hdr_r;
    frag_nxt  = frag_r;
    left_nxt  = left_r;
    chunk_nxt = chunk_r;
    ffrag_nxt = ffrag_r;
    last      = 1'b0;
    bnd       = '0;

    if (item_r.nal_start) begin
      if (abandon) begin
        seq_use = seq_r + 16'd1;
      end
      hdr_nxt   = item_r.data_byte;
      chunk_nxt = 11'd0;
      ffrag_nxt = 1'b1;
      left_nxt  = len - LEN_BITS'(1);
      if (CW'(len) <= mp_ext) begin
        // Whole NAL fits in one packet.
        last     = (len == LEN_BITS'(1));
        frag_nxt = 1'b0;
        bnd.cnt  = 2'd1;
        bnd.res[0].payload_byte = item_r.data_byte;
        bnd.res[0].packet_first = 1'b1;
        bnd.res[0].packet_last  = last;
        bnd.res[0].run_end      = 1'b1;
      end else begin
        // Header of a fragmented NAL is dropped.
        frag_nxt = 1'b1;
      end
    end else if (left_r == '0) begin
      // Stray byte with no NAL open.
      bnd.cnt = 2'd0;
    end else if (!frag_r) begin
      last     = (left_r == LEN_BITS'(1));
      left_nxt = left_r - LEN_BITS'(1);
      bnd.cnt  = 2'd1;
      bnd.res[0].payload_byte = item_r.data_byte;
      bnd.res[0].packet_first = 1'b0;
      bnd.res[0].packet_last  = last;
      bnd.res[0].run_end      = 1'b1;
    end else begin
      last      = (left_r == LEN_BITS'(1)) | (chunk_inc >= mp);
      left_nxt  = left_r - LEN_BITS'(1);
      chunk_nxt = chunk_inc[10:0];
      if (chunk_r == 11'd0) begin
        // New fragment: indicator, FU header, then the data byte.
        bnd.cnt = 2'd3;
        bnd.res[0].payload_byte = (hdr_r & NRI_MASK) | FU_A_TYPE;
        bnd.res[0].packet_first = 1'b1;
        bnd.res[1].payload_byte = fu_hdr;
        bnd.res[2].payload_byte = item_r.data_byte;
        bnd.res[2].packet_last  = last;
        bnd.res[2].run_end      = 1'b1;
      end else begin
        bnd.cnt = 2'd1;
        bnd.res[0].payload_byte = item_r.data_byte;
        bnd.res[0].packet_last  = last;
        bnd.res[0].run_end      = 1'b1;
      end
      if (last) begin
        chunk_nxt = 11'd0;
        ffrag_nxt = 1'b0;
      end
      if (left_r == LEN_BITS'(1)) begin
        frag_nxt  = 1'b0;
        ffrag_nxt = 1'b1;
        chunk_nxt = 11'd0;
      end
    end

    for (int i = 0; i < MAX_RESULTS; i++) begin
      bnd.res[i].packet_seq = seq_use;
    end
    seq_nxt = last ? (seq_use + 16'd1) : seq_use;
  end

  assign bundle      = bnd;
  assign bundle_load = item_take & (bnd.cnt != 2'd0);

  // Packetizer state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r   <= 16'd0;
      hdr_r   <= 8'd0;
      frag_r  <= 1'b0;
      left_r  <= '0;
      chunk_r <= 11'd0;
      ffrag_r <= 1'b1;
    end else if (item_take) begin
      seq_r   <= seq_nxt;
      hdr_r   <= hdr_nxt;
      frag_r  <= frag_nxt;
      left_r  <= left_nxt;
      chunk_r <= chunk_nxt;
      ffrag_r <= ffrag_nxt;
    end
  end

endmodule

// ===== hdl/hnfp_emit.sv =====
module hnfp_emit import hnfp_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         bundle_load,
  input  hnfp_bundle_t bundle,
  output logic         load_ok,
  output logic         out_valid,
  input  logic         out_stall,
  output hnfp_out_t    out_data
);

  hnfp_bundle_t bundle_r;
  logic         bvalid_r;
  logic [1:0]   idx_r;
  logic         out_valid_r;
  hnfp_out_t    out_data_r;

  logic         out_free;
  logic         emit;
  logic         done;
  hnfp_out_t    cur;

  // One result moves to the output register per cycle while the output register is free.
  assign out_free = ~out_valid_r | ~out_stall;
  assign emit     = bvalid_r & out_free;
  assign done     = emit & (idx_r == (bundle_r.cnt - 2'd1));
  assign load_ok  = ~bvalid_r | done;

  // Pick the result at the current position.
  always_comb begin
    case (idx_r)
      2'd0:    cur = bundle_r.res[0];
      2'd1:    cur = bundle_r.res[1];
      2'd2:    cur = bundle_r.res[2];
      default: cur = bundle_r.res[0];
    endcase
  end

  // Bundle register and read position.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bvalid_r <= 1'b0;
      idx_r    <= 2'd0;
    end else if (bundle_load) begin
      bvalid_r <= 1'b1;
      idx_r    <= 2'd0;
    end else if (done) begin
      bvalid_r <= 1'b0;
      idx_r    <= 2'd0;
    end else if (emit) begin
      idx_r <= idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (bundle_load) begin
      bundle_r <= bundle;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r <= cur;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== hdl/h264_nal_fu_a_packetizer_unit.sv =====
// Channel   Direction  Handshake            Payload
// in_       input      in_valid / in_stall  hnfp_in_t: data_byte, nal_start, nal_length
// out_      output     out_valid/out_stall  hnfp_out_t: payload byte, marks, seq, run_end
// cfg_      input      cfg_valid/cfg_ready  cfg_data: max_payload (12 bits)
//
// A NAL byte goes from the input register through the combinational core, the bundle
// register and the output register; the core takes one byte per cycle unless stalled.
// The first byte of each FU-A fragment causes three results, so the output register
// moves one result per cycle when free, and the input is held until all three are out.
// rst_n is synchronous; it loads max_payload with 1400 and returns the other control and
// packetizer state to its reset values; the data registers are not reset.
// A stall on the output holds the output register and backs up to in_stall.
module h264_nal_fu_a_packetizer_unit import hnfp_pkg::*; #(
  parameter int LEN_BITS = LEN_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  hnfp_in_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output hnfp_out_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [11:0] cfg_data
);

  logic         load_ok;
  logic         bundle_load;
  hnfp_bundle_t bundle;

  // The limit register takes a write in any cycle.
  assign cfg_ready = 1'b1;

  hnfp_core #(
    .LEN_BITS (LEN_BITS)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .cfg_valid   (cfg_valid),
    .cfg_data    (cfg_data),
    .load_ok     (load_ok),
    .bundle_load (bundle_load),
    .bundle      (bundle)
  );

  hnfp_emit u_emit (
    .clk         (clk),
    .rst_n       (rst_n),
    .bundle_load (bundle_load),
    .bundle      (bundle),
    .load_ok     (load_ok),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

endmodule
